// ===== sv/gdram_pixel_set_clear_sequencer_macros.svh =====
// Assertion helpers shared by the sequencer modules.
// Each macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef GDRAM_PIXEL_SET_CLEAR_SEQUENCER_MACROS_SVH
`define GDRAM_PIXEL_SET_CLEAR_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define GPSC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gpsc: same-cycle check failed");

// Next-cycle implication.
`define GPSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gpsc: next-cycle check failed");

`endif

// ===== sv/gpsc_pkg.sv =====
package gpsc_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Panel command bytes.
    localparam logic [7:0] CMD_EXTENDED    = 8'h34;
    localparam logic [7:0] CMD_GRAPHICS_ON = 8'h36;
    localparam logic [7:0] ADDR_BASE       = 8'h80;

    // Read-back progress.
    localparam logic [1:0] READS_NONE  = 2'd0;
    localparam logic [1:0] READS_DUMMY = 2'd1;

    // Beat positions inside a burst.
    localparam logic [2:0] BEAT_FIRST      = 3'd0;
    localparam logic [2:0] BEAT_SECOND     = 3'd1;
    localparam logic [2:0] BEAT_THIRD      = 3'd2;
    localparam logic [2:0] BEAT_FOURTH     = 3'd3;
    localparam logic [2:0] LAST_REQ_BEAT   = 3'd6;
    localparam logic [2:0] LAST_WRITE_BEAT = 3'd3;

    typedef enum logic [3:0] {
        BURST_NONE  = 4'b0001,
        BURST_DROP  = 4'b0010,
        BURST_REQ   = 4'b0100,
        BURST_WRITE = 4'b1000
    } t_burst_kind;

    typedef struct packed {
        t_burst_kind kind;
        logic [4:0]  row;
        logic [3:0]  col;
        logic [7:0]  hi;
        logic [7:0]  lo;
    } t_burst;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic [7:0] data;
        logic       dropped;
        logic       last;
    } t_beat;

endpackage

// ===== sv/gdram_pixel_set_clear_sequencer.sv =====
// Pixel set/clear sequencer for a 128x64 graphics RAM behind a parallel panel bus.
// Input stream (s_axis): tuser carries the request kind (set, clear, read return);
// tdata carries the pixel coordinates and the byte read back from the panel.
// Output stream (m_axis): one beat per bus operation; tuser tells command from data,
// write from read strobe, and flags a refused request; tlast closes each run.
// A set or clear request yields seven beats: mode, graphics-on, row and column
// commands, then three read strobes. The third read return yields four beats that
// re-address the word and write the modified high and low bytes.
// Throughput is set by the beat emitter, which issues one beat per cycle while the
// receiver holds m_axis_tready high; a refused request yields one beat, and read
// returns that produce nothing are absorbed without output, even during a burst.
// An accepted input beat reaches its first output beat through the input register,
// the emitter's burst state and the output register.
// Synchronous reset clears the pending read-back and empties these registers.
// When the receiver holds m_axis_tready low, the emitter halts on its current beat,
// the input register fills, and s_axis_tready drops until the output drains.
module gdram_pixel_set_clear_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] pix_x, [12:7] pix_y, [20:13] read_byte, [23:21] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] bus_byte
    output logic [7:0]  m_axis_tdata,
    // [0] bus_rs, [1] bus_rw, [2] dropped
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic [6:0] r_pix_x;
    logic [5:0] r_pix_y;
    logic [7:0] r_read_byte;

    gpsc_pkg::t_burst w_burst;
    gpsc_pkg::t_beat  w_beat;
    logic             w_can_load;
    logic             w_take;
    logic             w_load;

    // Items that produce nothing are absorbed even while a burst is being emitted.
    assign w_take = r_in_valid && (w_burst.kind == gpsc_pkg::BURST_NONE || w_can_load);
    assign w_load = w_take && (w_burst.kind != gpsc_pkg::BURST_NONE);
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req_type  <= s_axis_tuser;
            r_pix_x     <= s_axis_tdata[6:0];
            r_pix_y     <= s_axis_tdata[12:7];
            r_read_byte <= s_axis_tdata[20:13];
        end
    end

    gpsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_req_type  (r_req_type),
        .i_pix_x     (r_pix_x),
        .i_pix_y     (r_pix_y),
        .i_read_byte (r_read_byte),
        .o_burst     (w_burst)
    );

    gpsc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_burst    (w_burst),
        .i_m_ready  (m_axis_tready),
        .o_can_load (w_can_load),
        .o_m_valid  (m_axis_tvalid),
        .o_beat     (w_beat)
    );

    assign m_axis_tdata = w_beat.data;
    assign m_axis_tuser = {w_beat.dropped, w_beat.rw, w_beat.rs};
    assign m_axis_tlast = w_beat.last;

endmodule

// ===== sv/gpsc_core.sv =====
`include "gdram_pixel_set_clear_sequencer_macros.svh"

module gpsc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [1:0]           i_req_type,
    input  logic [6:0]           i_pix_x,
    input  logic [5:0]           i_pix_y,
    input  logic [7:0]           i_read_byte,
    output gpsc_pkg::t_burst     o_burst
);

    logic       r_pending,   n_pending;
    logic       r_op_clear,  n_op_clear;
    logic [4:0] r_word_row,  n_word_row;
    logic [3:0] r_word_col,  n_word_col;
    logic [3:0] r_bit_index, n_bit_index;
    logic [1:0] r_reads,     n_reads;
    logic [7:0] r_high_byte, n_high_byte;

    logic [7:0] w_mask;
    logic [7:0] w_hi_mod;
    logic [7:0] w_lo_mod;

    // One-hot mask within the byte; bit 0 of the word is the leftmost pixel.
    assign w_mask   = 8'h80 >> r_bit_index[2:0];
    assign w_hi_mod = r_op_clear ? (r_high_byte & ~w_mask) : (r_high_byte | w_mask);
    assign w_lo_mod = r_op_clear ? (i_read_byte & ~w_mask) : (i_read_byte | w_mask);

    always_comb begin
        n_pending   = r_pending;
        n_op_clear  = r_op_clear;
        n_word_row  = r_word_row;
        n_word_col  = r_word_col;
        n_bit_index = r_bit_index;
        n_reads     = r_reads;
        n_high_byte = r_high_byte;
        o_burst.kind = gpsc_pkg::BURST_NONE;
        o_burst.row  = r_word_row;
        o_burst.col  = r_word_col;
        o_burst.hi   = r_high_byte;
        o_burst.lo   = i_read_byte;
        unique case (i_req_type)
            gpsc_pkg::REQ_SET, gpsc_pkg::REQ_CLEAR: begin
                if (r_pending) begin
                    o_burst.kind = gpsc_pkg::BURST_DROP;
                end else begin
                    n_pending   = 1'b1;
                    n_op_clear  = i_req_type[0];
                    // The lower half of the screen sits in columns 8 to 15.
                    n_word_row  = i_pix_y[4:0];
                    n_word_col  = {i_pix_y[5], i_pix_x[6:4]};
                    n_bit_index = i_pix_x[3:0];
                    n_reads     = gpsc_pkg::READS_NONE;
                    o_burst.kind = gpsc_pkg::BURST_REQ;
                    o_burst.row  = n_word_row;
                    o_burst.col  = n_word_col;
                end
            end
            gpsc_pkg::REQ_READ: begin
                if (r_pending) begin
                    priority if (r_reads == gpsc_pkg::READS_NONE) begin
                        n_reads = gpsc_pkg::READS_DUMMY;
                    end else if (r_reads == gpsc_pkg::READS_DUMMY) begin
                        n_high_byte = i_read_byte;
                        n_reads     = r_reads + 2'd1;
                    end else begin
                        n_pending    = 1'b0;
                        n_reads      = gpsc_pkg::READS_NONE;
                        o_burst.kind = gpsc_pkg::BURST_WRITE;
                        o_burst.hi   = r_bit_index[3] ? r_high_byte : w_hi_mod;
                        o_burst.lo   = r_bit_index[3] ? w_lo_mod : i_read_byte;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_op_clear  <= 1'b0;
            r_word_row  <= '0;
            r_word_col  <= '0;
            r_bit_index <= '0;
            r_reads     <= gpsc_pkg::READS_NONE;
            r_high_byte <= '0;
        end else if (i_take) begin
            r_pending   <= n_pending;
            r_op_clear  <= n_op_clear;
            r_word_row  <= n_word_row;
            r_word_col  <= n_word_col;
            r_bit_index <= n_bit_index;
            r_reads     <= n_reads;
            r_high_byte <= n_high_byte;
        end
    end

    `GPSC_ASSERT_NEXT(a_req_sets_pending,
        i_take && o_burst.kind == gpsc_pkg::BURST_REQ, r_pending)
    `GPSC_ASSERT_NEXT(a_write_ends_pending,
        i_take && o_burst.kind == gpsc_pkg::BURST_WRITE, !r_pending)
    `GPSC_ASSERT_IMPLY(a_idle_no_reads, !r_pending, r_reads == gpsc_pkg::READS_NONE)

endmodule

// ===== sv/gpsc_emit.sv =====
`include "gdram_pixel_set_clear_sequencer_macros.svh"

module gpsc_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  gpsc_pkg::t_burst     i_burst,
    input  logic                 i_m_ready,
    output logic                 o_can_load,
    output logic                 o_m_valid,
    output gpsc_pkg::t_beat      o_beat
);

    logic                  r_busy;
    gpsc_pkg::t_burst_kind r_kind;
    logic [2:0]            r_idx;
    logic [4:0]            r_row;
    logic [3:0]            r_col;
    logic [7:0]            r_hi;
    logic [7:0]            r_lo;
    logic                  r_out_valid;
    gpsc_pkg::t_beat       r_out_beat;

    gpsc_pkg::t_beat w_beat;
    logic            w_out_free;
    logic            w_adv;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_adv      = r_busy && w_out_free;
    assign o_can_load = !r_busy || (w_adv && w_beat.last);
    assign o_m_valid  = r_out_valid;
    assign o_beat     = r_out_beat;

    always_comb begin
        w_beat = '0;
        unique case (r_kind)
            gpsc_pkg::BURST_REQ: begin
                w_beat.last = (r_idx == gpsc_pkg::LAST_REQ_BEAT);
                unique case (r_idx)
                    gpsc_pkg::BEAT_FIRST:  w_beat.data = gpsc_pkg::CMD_EXTENDED;
                    gpsc_pkg::BEAT_SECOND: w_beat.data = gpsc_pkg::CMD_GRAPHICS_ON;
                    gpsc_pkg::BEAT_THIRD:  w_beat.data = gpsc_pkg::ADDR_BASE + {3'd0, r_row};
                    gpsc_pkg::BEAT_FOURTH: w_beat.data = gpsc_pkg::ADDR_BASE + {4'd0, r_col};
                    default: begin
                        // Read strobes: the first one returns dummy data.
                        w_beat.rs = 1'b1;
                        w_beat.rw = 1'b1;
                    end
                endcase
            end
            gpsc_pkg::BURST_WRITE: begin
                w_beat.last = (r_idx == gpsc_pkg::LAST_WRITE_BEAT);
                unique case (r_idx)
                    gpsc_pkg::BEAT_FIRST:  w_beat.data = gpsc_pkg::ADDR_BASE + {3'd0, r_row};
                    gpsc_pkg::BEAT_SECOND: w_beat.data = gpsc_pkg::ADDR_BASE + {4'd0, r_col};
                    gpsc_pkg::BEAT_THIRD: begin
                        w_beat.rs   = 1'b1;
                        w_beat.data = r_hi;
                    end
                    default: begin
                        w_beat.rs   = 1'b1;
                        w_beat.data = r_lo;
                    end
                endcase
            end
            gpsc_pkg::BURST_DROP: begin
                w_beat.dropped = 1'b1;
                w_beat.last    = 1'b1;
            end
            default: begin
                w_beat.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= gpsc_pkg::BURST_NONE;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_kind <= i_burst.kind;
            r_idx  <= gpsc_pkg::BEAT_FIRST;
        end else if (w_adv && w_beat.last) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row <= i_burst.row;
            r_col <= i_burst.col;
            r_hi  <= i_burst.hi;
            r_lo  <= i_burst.lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_beat <= w_beat;
        end
    end

    `GPSC_ASSERT_IMPLY(a_req_idx_range, r_busy && r_kind == gpsc_pkg::BURST_REQ, r_idx <= gpsc_pkg::LAST_REQ_BEAT)
    `GPSC_ASSERT_IMPLY(a_write_idx_range, r_busy && r_kind == gpsc_pkg::BURST_WRITE, r_idx <= gpsc_pkg::LAST_WRITE_BEAT)
    `GPSC_ASSERT_IMPLY(a_drop_single, r_busy && r_kind == gpsc_pkg::BURST_DROP, r_idx == gpsc_pkg::BEAT_FIRST)

endmodule
